// ===== rtl/jmdp_pkg.sv =====
`default_nettype none

package jmdp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
        logic        arithmetic_coded;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_SECOND,
        PH_SEEK,
        PH_FFRUN,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_PREC,
        PH_H_HI,
        PH_H_LO,
        PH_W_HI,
        PH_W_LO,
        PH_DONE
    } t_phase;

    localparam logic [1:0] OC_NOT_JPEG = 2'd0;
    localparam logic [1:0] OC_HUFFMAN  = 2'd1;
    localparam logic [1:0] OC_ARITH    = 2'd2;
    localparam logic [1:0] OC_OTHER    = 2'd3;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF9   = 8'hC9;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [4:0] MK_RST_HI = 5'b11010;  // D0..D7
    localparam logic [15:0] LEN_SELF = 16'd2;

    // markers that end the scan without dimensions
    function automatic logic is_terminator(input logic [7:0] m);
        logic r;
        unique case (m)
            8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7, 8'hC8,
            8'hCA, 8'hCB, 8'hCD, 8'hCE, 8'hCF,
            8'hD8, 8'hD9, 8'hDA: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jpeg_marker_dimension_parser.sv =====
`default_nettype none

// Parses a JPEG byte stream, one byte per item, and returns at most one result item per
// file: not-jpeg, SOF0/SOF1 height and width, SOF9 arithmetic frame, or another terminating
// marker. A byte with stream_start set restarts the parser and is taken as the first byte.
// Every byte is handled in the cycle it is accepted, so one item is taken per clock while
// input ready is high; the result is registered, in the skid stage if the output register
// still holds one. A one-entry skid stage behind the output register keeps input accepted
// while a result waits; input ready drops only while both hold a result. Bytes after the
// result are dropped until the next stream_start.
module jpeg_marker_dimension_parser (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  jmdp_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output jmdp_pkg::t_out_item   o_out_item
);
    import jmdp_pkg::*;

    t_phase      r_phase, n_phase, w_cur;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_marker, n_marker;

    logic        r_out_valid, r_skid_valid;
    t_out_item   r_out, r_skid;

    logic        w_accept, w_take, w_res_valid;
    t_out_item   w_res;
    logic [7:0]  w_b;
    logic [15:0] w_skip_dec, w_len_skip;

    assign w_b        = i_in_item.data_byte;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_take     = r_out_valid & i_out_ready;
    assign w_cur      = i_in_item.stream_start ? PH_FIRST : r_phase;
    assign w_skip_dec = r_skip - 16'd1;
    assign w_len_skip = {r_len_hi, w_b} - LEN_SELF;

    assign o_in_ready  = ~r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // result decision
    always_comb begin
        w_res_valid = 1'b0;
        w_res       = '0;
        unique case (w_cur)
            PH_FIRST: begin
                if (w_b != BYTE_FF) begin
                    w_res_valid   = 1'b1;
                    w_res.outcome = OC_NOT_JPEG;
                end
            end
            PH_SECOND: begin
                if (w_b != MK_SOI) begin
                    w_res_valid   = 1'b1;
                    w_res.outcome = OC_NOT_JPEG;
                end
            end
            PH_FFRUN: begin
                if (w_b == MK_SOF9) begin
                    w_res_valid            = 1'b1;
                    w_res.outcome          = OC_ARITH;
                    w_res.arithmetic_coded = 1'b1;
                end else if (is_terminator(w_b)) begin
                    w_res_valid   = 1'b1;
                    w_res.outcome = OC_OTHER;
                end
            end
            PH_W_LO: begin
                w_res_valid        = 1'b1;
                w_res.outcome      = OC_HUFFMAN;
                w_res.frame_height = r_height;
                w_res.frame_width  = {r_len_hi, w_b};
            end
            default: begin
                w_res_valid = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase  = w_cur;
        n_skip   = r_skip;
        n_len_hi = r_len_hi;
        n_height = r_height;
        n_marker = r_marker;
        unique case (w_cur)
            PH_FIRST:  n_phase = PH_SECOND;
            PH_SECOND: n_phase = PH_SEEK;
            PH_SEEK: begin
                if (w_b == BYTE_FF) begin
                    n_phase = PH_FFRUN;
                end
            end
            PH_FFRUN: begin
                priority if (w_b == BYTE_FF) begin
                    n_phase = PH_FFRUN;
                end else if (w_b == BYTE_ZERO || w_b == MK_TEM || w_b[7:3] == MK_RST_HI) begin
                    n_phase = PH_SEEK;
                end else begin
                    n_marker = w_b;
                    n_phase  = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = w_b;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (r_marker == MK_SOF0 || r_marker == MK_SOF1) begin
                    n_phase = PH_PREC;
                end else begin
                    n_skip  = w_len_skip;
                    n_phase = (w_len_skip != 16'd0) ? PH_SKIP : PH_SEEK;
                end
            end
            PH_SKIP: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == 16'd0) begin
                    n_phase = PH_SEEK;
                end
            end
            PH_PREC: n_phase = PH_H_HI;
            PH_H_HI: begin
                n_height = {w_b, 8'h00};
                n_phase  = PH_H_LO;
            end
            PH_H_LO: begin
                n_height = {r_height[15:8], w_b};
                n_phase  = PH_W_HI;
            end
            PH_W_HI: begin
                n_len_hi = w_b;
                n_phase  = PH_W_LO;
            end
            PH_W_LO: n_phase = PH_DONE;
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
        if (w_res_valid) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_skip   <= n_skip;
            r_len_hi <= n_len_hi;
            r_height <= n_height;
            r_marker <= n_marker;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept & w_res_valid;
            end
        end else if (w_accept && w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept && w_res_valid) begin
                r_out <= w_res;
            end
        end else if (w_accept && w_res_valid) begin
            r_skid <= w_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jmdp_checker.sv =====
`default_nettype none

module jmdp_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input jmdp_pkg::t_in_item  i_in_item,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input jmdp_pkg::t_out_item o_out_item
);
    import jmdp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // dimensions only come with a huffman frame
    a_dims_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.outcome != OC_HUFFMAN
        |-> o_out_item.frame_height == 16'd0 && o_out_item.frame_width == 16'd0)
        else $error("dimensions on a non-frame result");

    a_arith_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.arithmetic_coded == (o_out_item.outcome == OC_ARITH))
        else $error("arithmetic flag disagrees with outcome");

    // a bad first byte of a new file is rejected on the next cycle
    a_bad_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.stream_start
        && i_in_item.data_byte != BYTE_FF && !o_out_valid
        |=> o_out_valid && o_out_item.outcome == OC_NOT_JPEG)
        else $error("bad first byte not reported");

endmodule

bind jpeg_marker_dimension_parser jmdp_checker u_jmdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import jmdp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [7:0] MK_RST7    = 8'hD7;
    localparam logic [7:0] MK_EOI     = 8'hD9;
    localparam logic [7:0] MK_SOS     = 8'hDA;
    localparam logic [7:0] MK_DHT     = 8'hC4;
    localparam logic [7:0] MK_DAC     = 8'hCC;
    localparam logic [7:0] MK_APP1    = 8'hE1;
    localparam logic [3:0] SOF_NIBBLE = 4'hC;

    localparam t_out_item RES_NONE     = '0;
    localparam t_out_item RES_NOT_JPEG = {OC_NOT_JPEG, 16'd0, 16'd0, 1'b0};
    localparam t_out_item RES_ARITH    = {OC_ARITH, 16'd0, 16'd0, 1'b1};
    localparam t_out_item RES_HUGE     = {OC_HUFFMAN, 16'hFFFF, 16'h0000, 1'b0};

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        t_out_item  res;
    } t_dir_row;

    t_dir_row dir_rows [26] = '{
        {BYTE_FF,   1'b0, 1'b0, RES_NONE},      // no start flag after reset
        {BYTE_ZERO, 1'b0, 1'b1, RES_NOT_JPEG},  // bad second byte
        {BYTE_ZERO, 1'b1, 1'b1, RES_NOT_JPEG},  // bad first byte
        {BYTE_FF,   1'b1, 1'b0, RES_NONE},
        {MK_SOI,    1'b0, 1'b0, RES_NONE},
        {BYTE_FF,   1'b0, 1'b0, RES_NONE},
        {MK_SOF9,   1'b0, 1'b1, RES_ARITH},
        {BYTE_FF,   1'b1, 1'b0, RES_NONE},
        {MK_SOI,    1'b0, 1'b0, RES_NONE},
        {BYTE_FF,   1'b0, 1'b0, RES_NONE},
        {BYTE_FF,   1'b0, 1'b0, RES_NONE},      // fill
        {BYTE_ZERO, 1'b0, 1'b0, RES_NONE},      // stuffed zero
        {BYTE_FF,   1'b0, 1'b0, RES_NONE},
        {MK_RST7,   1'b0, 1'b0, RES_NONE},
        {BYTE_FF,   1'b0, 1'b0, RES_NONE},
        {MK_TEM,    1'b0, 1'b0, RES_NONE},
        {BYTE_FF,   1'b0, 1'b0, RES_NONE},
        {MK_SOF1,   1'b0, 1'b0, RES_NONE},
        {8'h00,     1'b0, 1'b0, RES_NONE},
        {8'h08,     1'b0, 1'b0, RES_NONE},
        {8'h08,     1'b0, 1'b0, RES_NONE},
        {8'hFF,     1'b0, 1'b0, RES_NONE},
        {8'hFF,     1'b0, 1'b0, RES_NONE},
        {8'h00,     1'b0, 1'b0, RES_NONE},
        {8'h00,     1'b0, 1'b1, RES_HUGE},
        {8'h5A,     1'b0, 1'b0, RES_NONE}       // dropped after the result
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // typed expectation travels with the item
    logic      typed_has = 1'b0;
    t_out_item typed_res = '0;

    int send_idle_pct = 13;
    int recv_idle_pct = 74;
    int bytes_sent = 0;
    int cycle_count = 0;
    bit mismatch_seen = 1'b0;

    t_out_item awaited_outcomes [$];

    // parser state mirror
    t_phase      parse_ph = PH_FIRST;
    logic [15:0] skip_left = '0;
    logic [7:0]  hi_byte = '0;
    logic [15:0] height_acc = '0;
    logic [7:0]  seg_marker = '0;

    jpeg_marker_dimension_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic ends_scan(input logic [7:0] m);
        return (m[7:4] == SOF_NIBBLE && m != MK_SOF0 && m != MK_SOF1 && m != MK_SOF9
                && m != MK_DHT && m != MK_DAC)
               || m == MK_SOI || m == MK_EOI || m == MK_SOS;
    endfunction

    task automatic track_marker_byte(input t_in_item it, output logic got,
                                     output t_out_item res);
        logic [7:0]  b;
        logic [15:0] seg_len;
        b = it.data_byte;
        got = 1'b0;
        res = '0;
        if (it.stream_start) begin
            parse_ph   = PH_FIRST;
            skip_left  = '0;
            hi_byte    = '0;
            height_acc = '0;
            seg_marker = '0;
        end
        case (parse_ph)
            PH_FIRST: begin
                if (b != BYTE_FF) begin
                    got = 1'b1;
                    res.outcome = OC_NOT_JPEG;
                end else begin
                    parse_ph = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (b != MK_SOI) begin
                    got = 1'b1;
                    res.outcome = OC_NOT_JPEG;
                end else begin
                    parse_ph = PH_SEEK;
                end
            end
            PH_SEEK: begin
                if (b == BYTE_FF)
                    parse_ph = PH_FFRUN;
            end
            PH_FFRUN: begin
                if (b == BYTE_FF) begin
                    parse_ph = PH_FFRUN;
                end else if (b == BYTE_ZERO || b[7:3] == MK_RST_HI || b == MK_TEM) begin
                    parse_ph = PH_SEEK;
                end else if (b == MK_SOF9) begin
                    got = 1'b1;
                    res.outcome = OC_ARITH;
                    res.arithmetic_coded = 1'b1;
                end else if (ends_scan(b)) begin
                    got = 1'b1;
                    res.outcome = OC_OTHER;
                end else begin
                    seg_marker = b;
                    parse_ph = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                hi_byte = b;
                parse_ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (seg_marker == MK_SOF0 || seg_marker == MK_SOF1) begin
                    parse_ph = PH_PREC;
                end else begin
                    seg_len = {hi_byte, b};
                    skip_left = seg_len - LEN_SELF;
                    parse_ph = (skip_left != 0) ? PH_SKIP : PH_SEEK;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 0)
                    parse_ph = PH_SEEK;
            end
            PH_PREC: parse_ph = PH_H_HI;
            PH_H_HI: begin
                height_acc = {b, 8'h00};
                parse_ph = PH_H_LO;
            end
            PH_H_LO: begin
                height_acc[7:0] = b;
                parse_ph = PH_W_HI;
            end
            PH_W_HI: begin
                hi_byte = b;
                parse_ph = PH_W_LO;
            end
            PH_W_LO: begin
                got = 1'b1;
                res.outcome = OC_HUFFMAN;
                res.frame_height = height_acc;
                res.frame_width = {hi_byte, b};
            end
            default: parse_ph = PH_DONE;
        endcase
        if (got)
            parse_ph = PH_DONE;
    endtask

    task automatic send_checked(input logic [7:0] b, input logic s, input logic tk,
                                input t_out_item tr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_item   <= {b, s};
        typed_has <= tk;
        typed_res <= tr;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic s);
        send_checked(b, s, 1'b0, RES_NONE);
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_random_file();
        int          kind;
        int          nseg;
        logic [7:0]  m;
        logic [15:0] seg_len;
        logic [15:0] dim_h;
        logic [15:0] dim_w;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // plain noise, start flag anywhere
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            return;
        end
        if (kind < 11)
            send_byte(8'($urandom_range(255)), 1'b1);
        else
            send_byte(BYTE_FF, 1'b1);
        if (kind < 15)
            send_byte(8'($urandom_range(255)), 1'b0);
        else
            send_byte(MK_SOI, 1'b0);
        nseg = $urandom_range(0, 3);
        repeat (nseg) begin
            if ($urandom_range(3) == 0)
                send_byte(8'($urandom_range(254)), 1'b0);
            send_byte(BYTE_FF, 1'b0);
            while ($urandom_range(4) == 0)
                send_byte(BYTE_FF, 1'b0);
            case ($urandom_range(9))
                0: send_byte(BYTE_ZERO, 1'b0);
                1: send_byte({MK_RST_HI, 3'($urandom_range(7))}, 1'b0);
                2: send_byte(MK_TEM, 1'b0);
                default: begin
                    // markers that carry a length
                    case ($urandom_range(3))
                        0: m = MK_DHT;
                        1: m = MK_DAC;
                        2: m = 8'($urandom_range(8'h02, 8'hBF));
                        default: m = 8'($urandom_range(8'hDB, 8'hFE));
                    endcase
                    seg_len = 16'($urandom_range(2, 7));
                    send_byte(m, 1'b0);
                    send_byte(seg_len[15:8], 1'b0);
                    send_byte(seg_len[7:0], 1'b0);
                    repeat (seg_len - 2)
                        send_byte(8'($urandom_range(255)), 1'b0);
                end
            endcase
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                dim_h = pick_dim();
                dim_w = pick_dim();
                send_byte(BYTE_FF, 1'b0);
                send_byte($urandom_range(1) ? MK_SOF1 : MK_SOF0, 1'b0);
                repeat (3) send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(dim_h[15:8], 1'b0);
                send_byte(dim_h[7:0], 1'b0);
                send_byte(dim_w[15:8], 1'b0);
                send_byte(dim_w[7:0], 1'b0);
            end
            5: begin
                send_byte(BYTE_FF, 1'b0);
                send_byte(MK_SOF9, 1'b0);
            end
            6, 7: begin
                case ($urandom_range(3))
                    0: m = MK_SOI;
                    1: m = MK_EOI;
                    2: m = MK_SOS;
                    default: begin
                        do m = {SOF_NIBBLE, 4'($urandom_range(15))}; while (!ends_scan(m));
                    end
                endcase
                send_byte(BYTE_FF, 1'b0);
                send_byte(m, 1'b0);
            end
            8: begin
                // cut short inside a frame header
                send_byte(BYTE_FF, 1'b0);
                send_byte(MK_SOF0, 1'b0);
                send_byte(BYTE_ZERO, 1'b0);
            end
            default: begin
                send_byte(BYTE_FF, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b0);
            end
        endcase
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // segment whose length wraps below two; the marker after the header still
    // falls inside the skip, so no result may come
    task automatic send_long_segment(input logic [15:0] seg_len);
        send_byte(BYTE_FF, 1'b1);
        send_byte(MK_SOI, 1'b0);
        send_byte(BYTE_FF, 1'b0);
        send_byte(MK_APP1, 1'b0);
        send_byte(seg_len[15:8], 1'b0);
        send_byte(seg_len[7:0], 1'b0);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(BYTE_FF, 1'b0);
        send_byte(MK_EOI, 1'b0);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk) begin : p_monitor
        logic      got;
        t_out_item pred;
        t_out_item want;
        if (rst_n && in_valid && in_ready) begin
            track_marker_byte(in_item, got, pred);
            if (typed_has)
                awaited_outcomes.push_back(typed_res);
            else if (got)
                awaited_outcomes.push_back(pred);
        end
        if (rst_n && out_valid && out_ready) begin
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: unexpected result item oc=%0d h=%0d w=%0d ar=%0d", $time,
                         out_item.outcome, out_item.frame_height, out_item.frame_width,
                         out_item.arithmetic_coded);
                mismatch_seen = 1'b1;
            end else begin
                want = awaited_outcomes.pop_front();
                if (out_item.outcome !== want.outcome
                    || out_item.frame_height !== want.frame_height
                    || out_item.frame_width !== want.frame_width
                    || out_item.arithmetic_coded !== want.arithmetic_coded) begin
                    $display("%0t: mismatch expected oc=%0d h=%0d w=%0d ar=%0d", $time,
                             want.outcome, want.frame_height, want.frame_width,
                             want.arithmetic_coded);
                    $display("%0t:          actual   oc=%0d h=%0d w=%0d ar=%0d", $time,
                             out_item.outcome, out_item.frame_height, out_item.frame_width,
                             out_item.arithmetic_coded);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     awaited_outcomes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_checked(dir_rows[r].data, dir_rows[r].start, dir_rows[r].typed,
                         dir_rows[r].res);

        while (bytes_sent < 360)
            send_random_file();
        // sender holds off until the parser has nothing left to report
        wait_drained();

        send_idle_pct = 74;
        recv_idle_pct = 13;
        while (bytes_sent < 700)
            send_random_file();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_sent < 1030)
            send_random_file();
        send_long_segment(16'd0);
        send_long_segment(16'd1);

        wait_drained();
        repeat (10) @(posedge clk);
        if (!mismatch_seen)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
